[rtl/core/wbps_pkg.sv]
// Package for the wildcard byte pattern scanner: configuration types,
// register indexes and fixed widths. No dependencies.
`default_nettype none

package wbps_pkg;

  localparam int unsigned MaxPatternBytes = 8;
  localparam int unsigned PatternBits     = 8 * MaxPatternBytes;
  localparam int unsigned LengthBits      = 4;
  localparam int unsigned ByteIdxBits     = 3;
  localparam int unsigned CfgIndexBits    = 2;
  localparam int unsigned MatchOffsetBits = 32;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgPatternBytes = 2'd0,
    CfgWildcardFlags = 2'd1,
    CfgPatternLength = 2'd2,
    CfgUnused        = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [PatternBits-1:0]     pattern_bytes;
    logic [MaxPatternBytes-1:0] wildcard_flags;
    logic [LengthBits-1:0]      pattern_length;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/wbps_cfg_regs.sv]
// Configuration register file for the pattern scanner.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wbps_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [wbps_pkg::PatternBits-1:0]  cfg_data_i,
  output wbps_pkg::cfg_t                         cfg_o
);

  wbps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (wbps_pkg::cfg_index_e'(cfg_index_i))
        wbps_pkg::CfgPatternBytes: cfg_d.pattern_bytes = cfg_data_i;
        wbps_pkg::CfgWildcardFlags:
          cfg_d.wildcard_flags = cfg_data_i[wbps_pkg::MaxPatternBytes-1:0];
        wbps_pkg::CfgPatternLength:
          cfg_d.pattern_length = cfg_data_i[wbps_pkg::LengthBits-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= '0;
      cfg_q.wildcard_flags <= '0;
      cfg_q.pattern_length <= wbps_pkg::LengthBits'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/wbps_match.sv]
// Per-byte compare and search state update for the pattern scanner.
// Depends on wbps_pkg.
`default_nettype none

module wbps_match #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire wbps_pkg::cfg_t                         cfg_i,
  input  wire logic [7:0]                             data_byte_i,
  input  wire logic                                   last_i,
  input  wire logic [wbps_pkg::LengthBits-1:0]        matched_count_i,
  input  wire logic [OFFSET_BITS-1:0]                 candidate_start_i,
  input  wire logic [OFFSET_BITS-1:0]                 byte_offset_i,
  input  wire logic                                   already_found_i,
  output logic [wbps_pkg::LengthBits-1:0]             matched_count_o,
  output logic [OFFSET_BITS-1:0]                      candidate_start_o,
  output logic [OFFSET_BITS-1:0]                      byte_offset_o,
  output logic                                        already_found_o,
  output logic                                        found_o,
  output logic [wbps_pkg::MatchOffsetBits-1:0]        match_offset_o,
  output logic                                        search_done_o
);

  logic [wbps_pkg::LengthBits-1:0]  len;
  logic [wbps_pkg::LengthBits-1:0]  cnt;
  logic [wbps_pkg::LengthBits-1:0]  cnt_inc;
  logic [wbps_pkg::ByteIdxBits-1:0] idx;
  logic [7:0]                       pat;
  logic                             wild;
  logic                             hit;
  logic [OFFSET_BITS-1:0]           cand_next;

  always_comb begin
    // Clamp length into 1..MaxPatternBytes.
    if (cfg_i.pattern_length == '0) begin
      len = wbps_pkg::LengthBits'(1);
    end else if (cfg_i.pattern_length > wbps_pkg::LengthBits'(wbps_pkg::MaxPatternBytes)) begin
      len = wbps_pkg::LengthBits'(wbps_pkg::MaxPatternBytes);
    end else begin
      len = cfg_i.pattern_length;
    end
    cnt     = (matched_count_i >= len) ? '0 : matched_count_i;
    cnt_inc = cnt + wbps_pkg::LengthBits'(1);
    idx     = cnt[wbps_pkg::ByteIdxBits-1:0];
    pat     = cfg_i.pattern_bytes[8*idx +: 8];
    wild    = cfg_i.wildcard_flags[idx];
    hit     = wild ? ((data_byte_i & pat) == pat) : (data_byte_i == pat);
    cand_next = (cnt == '0) ? byte_offset_i : candidate_start_i;
  end

  always_comb begin
    matched_count_o   = matched_count_i;
    candidate_start_o = candidate_start_i;
    already_found_o   = already_found_i;
    found_o           = 1'b0;
    search_done_o     = 1'b0;
    match_offset_o    = '0;

    if (!already_found_i) begin
      if (hit) begin
        candidate_start_o = cand_next;
        if (cnt_inc >= len) begin
          found_o         = 1'b1;
          already_found_o = 1'b1;
          matched_count_o = '0;
          match_offset_o  = wbps_pkg::MatchOffsetBits'(cand_next);
        end else begin
          matched_count_o = cnt_inc;
        end
      end else begin
        matched_count_o = '0;
      end
      search_done_o = found_o | last_i;
    end

    // Saturate the offset at its top value.
    byte_offset_o = (&byte_offset_i) ? byte_offset_i
                                     : byte_offset_i + OFFSET_BITS'(1);

    // End of buffer: start over for the next byte.
    if (last_i) begin
      matched_count_o   = '0;
      candidate_start_o = '0;
      byte_offset_o     = '0;
      already_found_o   = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wildcard_byte_pattern_scan.sv]
// Wildcard byte pattern scanner, one byte per cycle while results are accepted.
// Each byte passes the input register, then the result register; the compare
// and state update fit between the two, so back-to-back bytes stream at one
// byte per cycle unless the result side stalls.
// Reset: asynchronous, active low; clears search state, config to defaults
// (pattern 0, no wildcards, length 1).
`default_nettype none

module wildcard_byte_pattern_scan #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // Byte stream in.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_in_buffer

  // Result stream out.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] match_offset
  output logic [1:0]       m_axis_tuser,   // [0] found, [1] search_done

  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  wbps_pkg::cfg_t cfg;

  wbps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;

  // Search state.
  logic [wbps_pkg::LengthBits-1:0] matched_count_q, matched_count_d;
  logic [OFFSET_BITS-1:0]          candidate_start_q, candidate_start_d;
  logic [OFFSET_BITS-1:0]          byte_offset_q, byte_offset_d;
  logic                            already_found_q, already_found_d;

  // Result register.
  logic                                  out_valid_q;
  logic                                  found_q, found_d;
  logic                                  done_q, done_d;
  logic [wbps_pkg::MatchOffsetBits-1:0]  offset_q, offset_d;

  logic out_free;
  logic advance;
  logic in_take;

  // Result register can load when empty or being drained this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  wbps_match #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .cfg_i             (cfg),
    .data_byte_i       (in_data_q),
    .last_i            (in_last_q),
    .matched_count_i   (matched_count_q),
    .candidate_start_i (candidate_start_q),
    .byte_offset_i     (byte_offset_q),
    .already_found_i   (already_found_q),
    .matched_count_o   (matched_count_d),
    .candidate_start_o (candidate_start_d),
    .byte_offset_o     (byte_offset_d),
    .already_found_o   (already_found_d),
    .found_o           (found_d),
    .match_offset_o    (offset_d),
    .search_done_o     (done_d)
  );

  // Hold the input byte until the result register takes its outcome.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Advance search state only when a byte is actually consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_count_q   <= '0;
      candidate_start_q <= '0;
      byte_offset_q     <= '0;
      already_found_q   <= 1'b0;
    end else if (advance) begin
      matched_count_q   <= matched_count_d;
      candidate_start_q <= candidate_start_d;
      byte_offset_q     <= byte_offset_d;
      already_found_q   <= already_found_d;
    end
  end

  // Result register: load on advance, drop once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q  <= found_d;
      done_q   <= done_d;
      offset_q <= offset_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = offset_q;
  assign m_axis_tuser  = {done_q, found_q};

endmodule

`default_nettype wire

[verif/wbps_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the wildcard byte pattern scanner: watches the byte, result
// and configuration channels, predicts every result and compares it.
// Depends on wbps_pkg for the configuration layout and register indexes.
module wbps_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [31:0] res_data_i,
  input  logic [1:0]  res_user_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        end_of_run_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned OffsetBits = 32;
  localparam logic [OffsetBits-1:0] OffsetTop = '1;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        done;
  } scan_result_t;

  scan_result_t            expected_results[$];
  scan_result_t            want;
  scan_result_t            got;
  scan_result_t            fresh;
  wbps_pkg::cfg_t          cfg_shadow;
  logic [3:0]              matched_count;
  logic [31:0]             candidate_start;
  logic [OffsetBits-1:0]   byte_offset;
  logic                    already_found;
  bit                      leftovers_reported;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    fail_count_o++;
  endtask

  // Advance the search by one byte and return the result that byte causes.
  task automatic scan_byte(input logic [7:0] data, input logic last,
                           output scan_result_t res);
    logic [3:0] len;
    logic [2:0] idx;
    logic [7:0] pat;
    logic       hit;
    res = '0;
    if (!already_found) begin
      if (cfg_shadow.pattern_length == 4'd0)
        len = 4'd1;
      else if (cfg_shadow.pattern_length > wbps_pkg::MaxPatternBytes)
        len = 4'(wbps_pkg::MaxPatternBytes);
      else
        len = cfg_shadow.pattern_length;
      if (matched_count >= len)
        matched_count = 4'd0;
      idx = matched_count[2:0];
      pat = cfg_shadow.pattern_bytes[idx*8 +: 8];
      hit = cfg_shadow.wildcard_flags[idx] ? ((data & pat) == pat) : (data == pat);
      if (hit) begin
        if (matched_count == 4'd0)
          candidate_start = byte_offset[31:0];
        matched_count++;
        if (matched_count >= len) begin
          res.found     = 1'b1;
          res.done      = 1'b1;
          res.offset    = candidate_start;
          already_found = 1'b1;
          matched_count = 4'd0;
        end
      end else begin
        matched_count = 4'd0;
      end
      if (last && !res.found)
        res.done = 1'b1;
    end
    if (byte_offset != OffsetTop)
      byte_offset++;
    if (last) begin
      matched_count   = 4'd0;
      candidate_start = '0;
      byte_offset     = '0;
      already_found   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      cfg_shadow.pattern_bytes  = '0;
      cfg_shadow.wildcard_flags = '0;
      cfg_shadow.pattern_length = 4'd1;
      matched_count      = '0;
      candidate_start    = '0;
      byte_offset        = '0;
      already_found      = 1'b0;
      leftovers_reported = 1'b0;
      fail_count_o       = 0;
      checked_o          = 0;
      pending_o          = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.found  = res_user_i[0];
        got.done   = res_user_i[1];
        got.offset = res_data_i;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {30'd0, res_user_i}, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
          if (got.offset !== want.offset)
            report_mismatch("match_offset", got.offset, want.offset);
          if (got.done !== want.done)
            report_mismatch("search_done", 32'(got.done), 32'(want.done));
        end
        checked_o++;
      end

      if (in_valid_i && in_ready_i) begin
        scan_byte(in_data_i, in_last_i, fresh);
        expected_results.push_back(fresh);
      end

      // A register write applies from the next byte on.
      if (cfg_valid_i && cfg_ready_i) begin
        case (wbps_pkg::cfg_index_e'(cfg_index_i))
          wbps_pkg::CfgPatternBytes:  cfg_shadow.pattern_bytes  = cfg_data_i;
          wbps_pkg::CfgWildcardFlags: cfg_shadow.wildcard_flags = cfg_data_i[7:0];
          wbps_pkg::CfgPatternLength: cfg_shadow.pattern_length = cfg_data_i[3:0];
          default: ;
        endcase
      end

      if (end_of_run_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        while (expected_results.size() != 0) begin
          want = expected_results.pop_front();
          report_mismatch("result never arrived", '0, want.offset);
        end
      end

      pending_o = expected_results.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the scanner testbench: clock, reset, byte and configuration stimulus,
// result sink and verdict. Depends on wbps_pkg, the scanner and wbps_checker.
module tb_top;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 4;
  // Far above the slowest clean run.
  localparam int unsigned CycleLimit  = 60000;
  localparam int unsigned HoldCycles  = 200;
  // Two register stages sit between a byte and its result; allow a little more.
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseItems  = 20;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned IdlePercent = 22;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;

  logic        end_of_run = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Shared knobs: random idling on both sides, and a request for a long stall.
  bit          idle_on  = 1'b1;
  int unsigned hold_seq = 0;

  int unsigned items_sent   = 0;
  int unsigned buffers_sent = 0;
  int unsigned cycle_count  = 0;

  // Our copy of what was last written, used to build matching buffers.
  logic [63:0] cur_pat   = '0;
  logic [7:0]  cur_flags = '0;
  logic [3:0]  cur_len   = 4'd1;

  always #(HalfPeriod) clk_i = ~clk_i;

  wildcard_byte_pattern_scan i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wbps_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),   // [7:0] data_byte
    .in_last_i    (s_axis_tlast),   // last_in_buffer
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),   // [31:0] match_offset
    .res_user_i   (m_axis_tuser),   // [0] found, [1] search_done
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .end_of_run_i (end_of_run),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Pattern length as the block uses it.
  function automatic int unsigned used_length();
    if (cur_len == 4'd0)
      return 1;
    if (cur_len > wbps_pkg::MaxPatternBytes)
      return wbps_pkg::MaxPatternBytes;
    return 32'(cur_len);
  endfunction

  // A data byte that matches pattern byte i; wildcard bytes get random extra bits.
  function automatic logic [7:0] pattern_byte(input int unsigned i);
    logic [7:0] pat;
    pat = cur_pat[i*8 +: 8];
    if (cur_flags[i] && $urandom_range(0, 3) != 0)
      return pat | 8'($urandom_range(0, 255));
    return pat;
  endfunction

  // Offer one byte, idling first at random; return at the falling edge after
  // the transaction, with tvalid still high so a following byte streams on.
  task automatic push_byte(input logic [7:0] data, input logic last);
    while (idle_on && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop the byte stream and hold until every expected result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write one register; leaves cfg_valid_i high for the caller to drop.
  task automatic write_reg(input wbps_pkg::cfg_index_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Reprogram the pattern with the block idle. Unused upper bits of the
  // narrow registers carry noise, which the block must drop.
  task automatic load_pattern(input logic [63:0] pat, input logic [7:0] flags,
                              input logic [3:0] len, input bit poke_spare);
    logic [63:0] word;
    wait_drained();
    write_reg(wbps_pkg::CfgPatternBytes, pat);
    word = {$urandom, $urandom};
    word[7:0] = flags;
    write_reg(wbps_pkg::CfgWildcardFlags, word);
    word = {$urandom, $urandom};
    word[3:0] = len;
    write_reg(wbps_pkg::CfgPatternLength, word);
    if (poke_spare)
      write_reg(wbps_pkg::CfgUnused, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    cur_pat   = pat;
    cur_flags = flags;
    cur_len   = len;
  endtask

  // Send one buffer: noise, then mostly a full pattern, sometimes one with a bad
  // byte or a missing tail, sometimes nothing but noise, then a short tail.
  task automatic send_buffer(input int unsigned prefix_len);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    int unsigned plen;
    int unsigned choice;
    int unsigned cut;
    int unsigned bad;
    plen   = used_length();
    choice = $urandom_range(0, 99);
    // Noise often repeats the first pattern byte to provoke the naive restart.
    repeat (prefix_len)
      bytes.push_back(($urandom_range(0, 3) == 0) ? cur_pat[7:0]
                                                  : 8'($urandom_range(0, 255)));
    if (choice < 70) begin
      for (int unsigned i = 0; i < plen; i++)
        bytes.push_back(pattern_byte(i));
    end else if (choice < 82) begin
      bad = $urandom_range(0, plen - 1);
      for (int unsigned i = 0; i < plen; i++) begin
        b = pattern_byte(i);
        if (i == bad)
          b = b ^ 8'($urandom_range(1, 255));
        bytes.push_back(b);
      end
    end else if (choice < 92) begin
      cut = $urandom_range(0, plen - 1);
      for (int unsigned i = 0; i < cut; i++)
        bytes.push_back(pattern_byte(i));
    end else begin
      repeat ($urandom_range(1, 10))
        bytes.push_back(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2))
      bytes.push_back(8'($urandom_range(0, 255)));
    if (bytes.size() == 0)
      bytes.push_back(8'($urandom_range(0, 255)));
    foreach (bytes[i])
      push_byte(bytes[i], i == bytes.size() - 1);
    buffers_sent++;
  endtask

  // Result sink: random tready, and a long hold-off counted here whenever the
  // stimulus bumps hold_seq, while the sender keeps offering bytes.
  initial begin : result_sink
    int unsigned seen_seq;
    int unsigned hold_left;
    seen_seq  = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles, %0d results still expected",
             $time, cycle_count, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    int unsigned pick;
    bit          paused;
    logic [63:0] rpat;
    logic [7:0]  rflags;
    logic [3:0]  rlen;
    paused = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Reset pattern is a single exact zero byte: hit at
    // offset zero, then the final byte is ignored since the search is done.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // Three bytes, the middle one a wildcard needing bits 5:4 set.
    // Mismatch, then a match starting at offset one, then an ignored tail.
    load_pattern(64'h0000_0000_00A5_30C3, 8'b0000_0010, 4'd3, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hF3, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b1);
    // Naive restart: the second C3 fails the wildcard and is not rechecked
    // as a first byte, so the buffer ends without a match.
    push_byte(8'hC3, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hF3, 1'b0);
    push_byte(8'hA5, 1'b1);

    // Length zero acts as one; wildcard on bit 7.
    load_pattern(64'h0000_0000_0000_0080, 8'h01, 4'd0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b1);

    // Length above eight acts as eight; the match completes on the final byte.
    load_pattern('1, 8'h00, 4'd15, 1'b0);
    repeat (7) push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);

    // Random part, one pattern setting per phase.
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: load_pattern('0, 8'hFF, 4'd8, 1'b0);
        1: load_pattern('1, 8'h00, 4'd1, 1'b0);
        2: load_pattern('1, 8'hFF, 4'd15, 1'b0);
        default: begin
          rpat   = {$urandom, $urandom};
          rflags = 8'($urandom_range(0, 255));
          pick   = $urandom_range(0, 19);
          if (pick == 0)
            rlen = 4'd0;
          else if (pick < 3)
            rlen = 4'($urandom_range(9, 15));
          else if (pick < 6)
            rlen = 4'($urandom_range(5, 8));
          else
            rlen = 4'($urandom_range(1, 4));
          load_pattern(rpat, rflags, rlen, phase == 4);
        end
      endcase

      // One phase streams with no idling on either side.
      idle_on = (phase != 3);
      // One phase starts with the sink stalled long enough to back up the input.
      if (phase == 5)
        hold_seq++;
      // One long buffer pushes the offsets past eight bits.
      if (phase == 7)
        send_buffer(260);

      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if (phase == 8 && !paused && items_sent - phase_start >= PhaseItems / 2) begin
          paused = 1'b1;
          wait_drained();
        end
        send_buffer($urandom_range(0, 6));
      end
    end

    wait_drained();
    end_of_run <= 1'b1;
    @(negedge clk_i);
    @(negedge clk_i);

    $display("Scanned %0d bytes in %0d buffers over %0d pattern settings; %0d results checked.",
             items_sent, buffers_sent, PhaseCount + 4, checked);
    $display("Settings covered lengths 0, 1, 8 and above, all-exact and all-wildcard bytes.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches counted", fail_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
